[rtl/core/sdie_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// sdie_pkg : shared types and constants for the spring-damper step block
// Widths of the fixed-point datapath, register codes, sequencer states and
// the divider result word.
// ============================================================================
package sdie_pkg;

    // Field widths (Q16.16 values, 20-bit time step)
    localparam int FRAC_W  = 16;
    localparam int X_W     = 32;
    localparam int DT_W    = 20;
    localparam int CFG_W   = 31;
    localparam int THR_W   = 32;
    localparam int D_W     = X_W + 1;          // position - goal, exact
    localparam int MAG_W   = 32;               // |d|, |v|, |new speed|

    // Intermediate widths
    localparam int KDT_W   = 35;               // (k*dt) >> 16
    localparam int KDT2_W  = 39;               // (kdt*dt) >> 16
    localparam int DEN_W   = 40;               // m + c*dt + k*dt^2
    localparam int P1_W    = 64;               // signed m*v
    localparam int NUM_W   = 68;               // numerator magnitude
    localparam int QUO_W   = 33;               // quotient, clamped at 2^32
    localparam int PMAG_W  = 36;               // |nv|*dt >> 16
    localparam int NX_W    = X_W + 6;          // position sum before clamp
    localparam int NV2_W   = 63;
    localparam int D2_W    = 64;
    localparam int ACC_W   = 97;               // exact energy term
    localparam int SUM_W   = 64;               // Q32.32 energy sum
    localparam int E_SHIFT = 17;               // 0.5 and Q48 -> Q32 trim
    localparam int HALF_W  = 32;               // split of wide operands

    // Shared multiplier
    localparam int MUL_A_W = 35;
    localparam int MUL_B_W = 32;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Divider: two quotient bits per cycle
    localparam int DIV_STEPS = NUM_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Stream word widths
    localparam int S_TDATA_W = 120;            // 116 bits of fields, byte padded
    localparam int M_TDATA_W = 64;
    localparam int IDX_W     = 2;

    // Register reset values
    localparam logic [CFG_W-1:0] MASS_RST      = 31'd65536;
    localparam logic [CFG_W-1:0] STIFFNESS_RST = 31'd65536;
    localparam logic [CFG_W-1:0] DAMPING_RST   = 31'd65536;
    localparam logic [THR_W-1:0] THRESHOLD_RST = 32'd4295;

    typedef enum logic [IDX_W-1:0] {
        REG_MASS      = 2'd0,
        REG_STIFFNESS = 2'd1,
        REG_DAMPING   = 2'd2,
        REG_THRESHOLD = 2'd3
    } cfg_reg_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_KDT,
        S_CDT,
        S_KDT2,
        S_P1,
        S_P2,
        S_NUM,
        S_DSTART,
        S_DWAIT,
        S_SAT,
        S_STEP,
        S_NV2,
        S_D2,
        S_EM0,
        S_EM1,
        S_EK0,
        S_EK1,
        S_EACC,
        S_ESUM,
        S_DONE
    } seq_state_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
    } div_res_t;

endpackage

[rtl/core/spring_damper_implicit_euler_step.sv]
`timescale 1ns / 1ps
// ============================================================================
// spring_damper_implicit_euler_step : one implicit Euler spring-damper step
// Per component: new speed and position from position, speed, goal and dt,
// plus a saturating Q32.32 energy sum that reports finished on the last one.
// ============================================================================
// One word is in flight at a time: the sequencer walks the divider loop (two
// bits a cycle over a 68-bit numerator) and 12 passes through one shared
// multiplier, loads the result word and only then returns to idle.
// s_tready is high only while the sequencer idles.
// Reset (aresetn low, synchronous): registers to defaults, energy sum cleared,
// output empty.
module spring_damper_implicit_euler_step import sdie_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // position, speed, goal, time_step, zero pad
    input  logic                 s_tlast,   // last_component
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // new_position, new_speed
    output logic                 m_tlast,   // is_last
    output logic                 m_tuser,   // finished
    // register writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [IDX_W-1:0]     cfg_index,
    input  logic [THR_W-1:0]     cfg_data
);

    localparam logic [MAG_W-1:0] NEG_LIM = {1'b1, {(MAG_W-1){1'b0}}};
    localparam logic [MAG_W-1:0] POS_LIM = {1'b0, {(MAG_W-1){1'b1}}};

    seq_state_t state_reg, state_next;

    // configuration
    logic [CFG_W-1:0] mass_reg, stiffness_reg, damping_reg;
    logic [THR_W-1:0] threshold_reg;

    // item registers
    logic [X_W-1:0]    x_reg;
    logic [MAG_W-1:0]  vmag_reg;
    logic              v_neg_reg;
    logic [DT_W-1:0]   dt_reg;
    logic              last_reg;
    logic [D_W-1:0]    d_reg;
    logic [MAG_W-1:0]  dmag_reg;
    logic [KDT_W-1:0]  kdt_reg, cdt_reg;
    logic [KDT2_W-1:0] kdt2_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [P1_W-1:0]   p1s_reg;
    logic [NUM_W:0]    num_reg;
    logic [X_W-1:0]    nv_reg, nx_reg;
    logic [MAG_W-1:0]  nvmag_reg;
    logic [NV2_W-1:0]  nv2_reg;
    logic [D2_W-1:0]   d2_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [SUM_W-1:0]  esum_reg;

    // output word
    logic             m_valid_reg;
    logic [X_W-1:0]   out_pos_reg, out_speed_reg;
    logic             out_last_reg, out_fin_reg;

    // shared units
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  prod_reg;
    logic               div_start;
    div_res_t           div_res;

    logic               in_take, out_free, out_load;

    // combinational helpers
    logic [D_W-1:0]     d_abs;
    logic [DEN_W-1:0]   den_sum;
    logic [P1_W-1:0]    p1_ext;
    logic [NUM_W:0]     p1x, p2x;
    logic [MAG_W-1:0]   sat_mag;
    logic [PMAG_W-1:0]  pmag;
    logic [NX_W-1:0]    x_ext, p_ext, nx_sum;
    logic [X_W-1:0]     nx_sat;
    logic [SUM_W-1:0]   energy;
    logic [SUM_W:0]     esum_add;
    logic               below_thr;

    sdie_mul u_mul (
        .aclk     (aclk),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .prod_reg (prod_reg)
    );

    sdie_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_reg),
        .den     (den_reg),
        .div_res (div_res)
    );

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;
    assign in_take   = s_tvalid && s_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (s_tvalid) state_next = S_KDT;
            S_KDT:    state_next = S_CDT;
            S_CDT:    state_next = S_KDT2;
            S_KDT2:   state_next = S_P1;
            S_P1:     state_next = S_P2;
            S_P2:     state_next = S_NUM;
            S_NUM:    state_next = S_DSTART;
            S_DSTART: state_next = S_DWAIT;
            S_DWAIT:  if (div_res.done) state_next = S_SAT;
            S_SAT:    state_next = S_STEP;
            S_STEP:   state_next = S_NV2;
            S_NV2:    state_next = S_D2;
            S_D2:     state_next = S_EM0;
            S_EM0:    state_next = S_EM1;
            S_EM1:    state_next = S_EK0;
            S_EK0:    state_next = S_EK1;
            S_EK1:    state_next = S_EACC;
            S_EACC:   state_next = S_ESUM;
            S_ESUM:   state_next = S_DONE;
            S_DONE:   if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // sequencer outputs: handshake, divider start, multiplier operands
    always_comb begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        case (state_reg)
            S_IDLE:   s_tready = 1'b1;
            S_KDT: begin
                mul_a = MUL_A_W'(stiffness_reg);
                mul_b = MUL_B_W'(dt_reg);
            end
            S_CDT: begin
                mul_a = MUL_A_W'(damping_reg);
                mul_b = MUL_B_W'(dt_reg);
            end
            S_KDT2: begin
                mul_a = kdt_reg;
                mul_b = MUL_B_W'(dt_reg);
            end
            S_P1: begin
                mul_a = MUL_A_W'(mass_reg);
                mul_b = vmag_reg;
            end
            S_P2: begin
                mul_a = kdt_reg;
                mul_b = dmag_reg;
            end
            S_DSTART: div_start = 1'b1;
            S_STEP: begin
                mul_a = MUL_A_W'(nvmag_reg);
                mul_b = MUL_B_W'(dt_reg);
            end
            S_NV2: begin
                mul_a = MUL_A_W'(nvmag_reg);
                mul_b = nvmag_reg;
            end
            S_D2: begin
                mul_a = MUL_A_W'(dmag_reg);
                mul_b = dmag_reg;
            end
            S_EM0: begin
                mul_a = MUL_A_W'(mass_reg);
                mul_b = nv2_reg[HALF_W-1:0];
            end
            S_EM1: begin
                mul_a = MUL_A_W'(mass_reg);
                mul_b = MUL_B_W'(nv2_reg[NV2_W-1:HALF_W]);
            end
            S_EK0: begin
                mul_a = MUL_A_W'(stiffness_reg);
                mul_b = d2_reg[HALF_W-1:0];
            end
            S_EK1: begin
                mul_a = MUL_A_W'(stiffness_reg);
                mul_b = d2_reg[D2_W-1:HALF_W];
            end
            S_DONE:   out_load = out_free;
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // datapath helpers
    always_comb begin
        d_abs   = d_reg[D_W-1] ? (~d_reg + 1'b1) : d_reg;
        den_sum = DEN_W'(mass_reg) + DEN_W'(cdt_reg) + DEN_W'(kdt2_reg);
        p1_ext  = {1'b0, prod_reg[P1_W-2:0]};
        p1x     = {{(NUM_W+1-P1_W){p1s_reg[P1_W-1]}}, p1s_reg};
        p2x     = {{(NUM_W+1-PROD_W){1'b0}}, prod_reg};

        // clamp quotient to the signed 32-bit range
        if (num_reg[NUM_W])
            sat_mag = (div_res.quo > QUO_W'(NEG_LIM)) ? NEG_LIM : div_res.quo[MAG_W-1:0];
        else
            sat_mag = (div_res.quo > QUO_W'(POS_LIM)) ? POS_LIM : div_res.quo[MAG_W-1:0];

        // position update and clamp
        pmag   = prod_reg[PMAG_W+FRAC_W-1:FRAC_W];
        x_ext  = {{(NX_W-X_W){x_reg[X_W-1]}}, x_reg};
        p_ext  = {{(NX_W-PMAG_W){1'b0}}, pmag};
        nx_sum = nv_reg[X_W-1] ? (x_ext - p_ext) : (x_ext + p_ext);
        if (!nx_sum[NX_W-1] && (|nx_sum[NX_W-2:X_W-1]))
            nx_sat = POS_LIM;
        else if (nx_sum[NX_W-1] && !(&nx_sum[NX_W-2:X_W-1]))
            nx_sat = NEG_LIM;
        else
            nx_sat = nx_sum[X_W-1:0];

        // energy term: trim to Q32.32, saturate, then saturating add
        energy    = (|acc_reg[ACC_W-1:E_SHIFT+SUM_W]) ? {SUM_W{1'b1}}
                                                      : acc_reg[E_SHIFT+SUM_W-1:E_SHIFT];
        esum_add  = {1'b0, esum_reg} + {1'b0, energy};
        below_thr = (esum_reg[SUM_W-1:THR_W] == '0) && (esum_reg[THR_W-1:0] <= threshold_reg);
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mass_reg      <= MASS_RST;
            stiffness_reg <= STIFFNESS_RST;
            damping_reg   <= DAMPING_RST;
            threshold_reg <= THRESHOLD_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                REG_MASS:      mass_reg      <= cfg_data[CFG_W-1:0];
                REG_STIFFNESS: stiffness_reg <= cfg_data[CFG_W-1:0];
                REG_DAMPING:   damping_reg   <= cfg_data[CFG_W-1:0];
                REG_THRESHOLD: threshold_reg <= cfg_data;
                default:       threshold_reg <= threshold_reg;
            endcase
        end
    end

    // energy sum: the only state kept across items
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esum_reg <= '0;
        end else if (state_reg == S_ESUM) begin
            esum_reg <= esum_add[SUM_W] ? {SUM_W{1'b1}} : esum_add[SUM_W-1:0];
        end else if (out_load && last_reg) begin
            esum_reg <= '0;
        end
    end

    // item datapath, one step per sequencer state
    always_ff @(posedge aclk) begin
        if (in_take) begin
            x_reg     <= s_tdata[X_W-1:0];
            vmag_reg  <= s_tdata[2*X_W-1] ? (~s_tdata[2*X_W-1:X_W] + 1'b1)
                                          : s_tdata[2*X_W-1:X_W];
            v_neg_reg <= s_tdata[2*X_W-1];
            d_reg     <= {s_tdata[X_W-1], s_tdata[X_W-1:0]}
                         - {s_tdata[3*X_W-1], s_tdata[3*X_W-1:2*X_W]};
            dt_reg    <= s_tdata[3*X_W+DT_W-1:3*X_W];
            last_reg  <= s_tlast;
        end
        case (state_reg)
            S_KDT:  dmag_reg <= d_abs[MAG_W-1:0];
            S_CDT:  kdt_reg  <= prod_reg[KDT_W+FRAC_W-1:FRAC_W];
            S_KDT2: cdt_reg  <= prod_reg[KDT_W+FRAC_W-1:FRAC_W];
            S_P1:   kdt2_reg <= prod_reg[KDT2_W+FRAC_W-1:FRAC_W];
            S_P2: begin
                // a zero denominator only comes from zero mass: use one LSB
                if (mass_reg == '0 && cdt_reg == '0 && kdt2_reg == '0)
                    den_reg <= DEN_W'(1);
                else
                    den_reg <= den_sum;
                p1s_reg <= v_neg_reg ? (~p1_ext + 1'b1) : p1_ext;
            end
            // spring term enters negated: subtract for d >= 0
            S_NUM:  num_reg <= d_reg[D_W-1] ? (p1x + p2x) : (p1x - p2x);
            S_SAT: begin
                nvmag_reg <= sat_mag;
                nv_reg    <= num_reg[NUM_W] ? (~sat_mag + 1'b1) : sat_mag;
            end
            S_NV2:  nx_reg  <= nx_sat;
            S_D2:   nv2_reg <= prod_reg[NV2_W-1:0];
            S_EM0:  d2_reg  <= prod_reg[D2_W-1:0];
            S_EM1:  acc_reg <= ACC_W'(prod_reg);
            S_EK0:  acc_reg <= acc_reg + ACC_W'({prod_reg, {HALF_W{1'b0}}});
            S_EK1:  acc_reg <= acc_reg + ACC_W'(prod_reg);
            S_EACC: acc_reg <= acc_reg + ACC_W'({prod_reg, {HALF_W{1'b0}}});
            default: begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_pos_reg   <= nx_reg;
            out_speed_reg <= nv_reg;
            out_last_reg  <= last_reg;
            out_fin_reg   <= last_reg && below_thr;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_speed_reg, out_pos_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_fin_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // one item at a time: no word taken right after a word was taken
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        in_take |=> !s_tready)
        else $error("input taken while an item is in flight");

    // divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_res.done |-> (state_reg == S_DWAIT))
        else $error("divider done outside the wait state");

    // the energy sum is cleared after a last component is sent
    a_sum_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && last_reg) |=> (esum_reg == '0))
        else $error("energy sum not cleared after last component");

    // finished is only reported on a last component
    a_fin_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tuser || m_tlast))
        else $error("finished set on a component that is not last");

endmodule

[rtl/core/sdie_mul.sv]
`timescale 1ns / 1ps
// ============================================================================
// sdie_mul : shared unsigned multiplier
// One 35x32 product per cycle, registered at the output.
// ============================================================================
module sdie_mul import sdie_pkg::*; (
    input  logic               aclk,
    input  logic [MUL_A_W-1:0] mul_a,
    input  logic [MUL_B_W-1:0] mul_b,
    output logic [PROD_W-1:0]  prod_reg
);

    // product register, no reset (payload only)
    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end

endmodule

[rtl/core/sdie_div.sv]
`timescale 1ns / 1ps
// ============================================================================
// sdie_div : iterative restoring divider
// Divides the magnitude of a signed numerator by an unsigned denominator,
// two quotient bits per cycle. The quotient saturates at 2^32.
// ============================================================================
module sdie_div import sdie_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W:0]   num,      // two's complement
    input  logic [DEN_W-1:0] den,      // nonzero
    output div_res_t         div_res
);

    localparam logic [QUO_W-1:0] QUO_MAX = {1'b1, {(QUO_W-1){1'b0}}};

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0]     nsh_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [QUO_W-1:0]     quo_reg;

    logic [NUM_W:0]       num_abs;
    logic [DEN_W:0]       t1, t2, r1, r2;
    logic                 ge1, ge2;
    logic [QUO_W+1:0]     q_ext;

    assign num_abs = num[NUM_W] ? (~num + 1'b1) : num;

    // two compare-subtract steps per cycle
    always_comb begin
        t1    = {rem_reg, nsh_reg[NUM_W-1]};
        ge1   = (t1 >= {1'b0, den});
        r1    = ge1 ? (t1 - {1'b0, den}) : t1;
        t2    = {r1[DEN_W-1:0], nsh_reg[NUM_W-2]};
        ge2   = (t2 >= {1'b0, den});
        r2    = ge2 ? (t2 - {1'b0, den}) : t2;
        q_ext = {quo_reg, ge1, ge2};
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_STEPS - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            nsh_reg <= num_abs[NUM_W-1:0];
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (busy_reg) begin
            nsh_reg <= {nsh_reg[NUM_W-3:0], 2'b00};
            rem_reg <= r2[DEN_W-1:0];
            quo_reg <= (q_ext > (QUO_W+2)'(QUO_MAX)) ? QUO_MAX : q_ext[QUO_W-1:0];
        end
    end

    assign div_res.done = done_reg;
    assign div_res.quo  = quo_reg;

endmodule

[tb/spring_damper_implicit_euler_step_test.sv]
`timescale 1ns / 1ps
// ============================================================================
// spring_damper_implicit_euler_step_test : self-checking bench for the step
// Drives component words through the input stream and checks every result
// word against an in-bench fixed-point spring-damper predictor, including
// the saturating energy sum and the finished flag. Covers saturation, zero
// mass, threshold edges and randomized register settings, with random
// source gaps and sink stalls.
// ============================================================================
module spring_damper_implicit_euler_step_test import sdie_pkg::*; ();

    localparam int     BLOCK_LATENCY = 53;
    localparam longint S32_MAX       = 64'sd2147483647;
    localparam longint S32_MIN       = -64'sd2147483648;

    typedef struct packed {
        logic signed [X_W-1:0] position;
        logic signed [X_W-1:0] speed;
        logic signed [X_W-1:0] goal;
        logic [DT_W-1:0]       time_step;
        logic                  last_component;
    } component_t;

    typedef struct packed {
        logic signed [X_W-1:0] new_position;
        logic signed [X_W-1:0] new_speed;
        logic                  is_last;
        logic                  finished;
    } step_result_t;

    typedef enum {MOTION_REST, MOTION_TYPICAL, MOTION_WILD} motion_kind_t;

    // DUT ports
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;   // position, speed, goal, time_step, zero pad
    logic                 s_tlast   = 1'b0; // last_component
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // new_position, new_speed
    logic                 m_tlast;          // is_last
    logic                 m_tuser;          // finished
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [IDX_W-1:0]     cfg_index = '0;
    logic [THR_W-1:0]     cfg_data  = '0;

    // Predictor copy of the registers and the energy sum
    logic [CFG_W-1:0] spring_mass;
    logic [CFG_W-1:0] spring_k;
    logic [CFG_W-1:0] spring_c;
    logic [THR_W-1:0] finish_threshold;
    logic [SUM_W-1:0] energy_acc;

    step_result_t pending_steps[$];

    int tx_gap_pct   = 25;
    int rx_stall_pct = 25;
    int rx_hold      = 0;
    int n_errors     = 0;
    int n_results    = 0;
    int n_components = 0;
    int n_values     = 0;
    int n_finished   = 0;
    int n_settings   = 0;

    spring_damper_implicit_euler_step u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void apply_register(input cfg_reg_t idx, input logic [THR_W-1:0] data);
        case (idx)
            REG_MASS:      spring_mass      = data[CFG_W-1:0];
            REG_STIFFNESS: spring_k         = data[CFG_W-1:0];
            REG_DAMPING:   spring_c         = data[CFG_W-1:0];
            REG_THRESHOLD: finish_threshold = data;
            default: ;
        endcase
    endfunction

    // One implicit Euler step; energy is the truncated, saturated Q32.32 term
    function automatic void integrate_component(input component_t c, output step_result_t r,
                                                output logic [SUM_W-1:0] energy);
        longint       x, v, d, nv, nx, step_len;
        logic [127:0] dt, dmag, vmag, kdt, den, p1, p2, num, q, nvmag, prod, e;
        logic         neg;
        x    = c.position;
        v    = c.speed;
        d    = x - longint'(c.goal);
        dt   = 128'(c.time_step);
        dmag = (d < 0) ? 128'(-d) : 128'(d);
        vmag = (v < 0) ? 128'(-v) : 128'(v);

        // denominator m + c*dt + (k*dt)*dt, each term cut to Q16.16
        kdt = (128'(spring_k) * dt) >> FRAC_W;
        den = 128'(spring_mass) + ((128'(spring_c) * dt) >> FRAC_W) + ((kdt * dt) >> FRAC_W);
        if (den == 0)
            den = 1;

        // numerator m*v - kdt*d, exact, two's complement at 128 bits
        p1 = 128'(spring_mass) * vmag;
        if (v < 0)
            p1 = -p1;
        p2 = kdt * dmag;
        if (d >= 0)
            p2 = -p2;
        num = p1 + p2;
        neg = num[127];
        if (neg)
            num = -num;

        q = num / den;
        if (q > 128'd4294967296)
            q = 128'd4294967296;
        if (neg)
            nv = (q > 128'd2147483648) ? S32_MIN : -longint'(q[63:0]);
        else
            nv = (q > 128'd2147483647) ? S32_MAX : longint'(q[63:0]);

        // position step rounds toward zero, then clamps
        nvmag    = (nv < 0) ? 128'(-nv) : 128'(nv);
        prod     = (nvmag * dt) >> FRAC_W;
        step_len = prod[63:0];
        nx       = (nv < 0) ? x - step_len : x + step_len;
        if (nx > S32_MAX)
            nx = S32_MAX;
        else if (nx < S32_MIN)
            nx = S32_MIN;

        // 0.5*(m*nv^2 + k*d^2), Q48.. down to Q32.32
        e = 128'(spring_mass) * nvmag * nvmag + 128'(spring_k) * dmag * dmag;
        energy = ((e >> (E_SHIFT + SUM_W)) != 0) ? '1 : SUM_W'(e >> E_SHIFT);

        r.new_position = 32'(nx);
        r.new_speed    = 32'(nv);
        r.is_last      = c.last_component;
        r.finished     = 1'b0;
    endfunction

    function automatic void record_component(input component_t c);
        step_result_t     r;
        logic [SUM_W-1:0] e;
        logic [SUM_W:0]   total;
        integrate_component(c, r, e);
        total      = {1'b0, energy_acc} + {1'b0, e};
        energy_acc = total[SUM_W] ? '1 : total[SUM_W-1:0];
        if (c.last_component) begin
            r.finished = (energy_acc <= SUM_W'(finish_threshold));
            energy_acc = '0;
            n_values++;
            if (r.finished)
                n_finished++;
        end
        pending_steps = {pending_steps, r};
        n_components++;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int idle_length();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(20, 150);
        return $urandom_range(1, 3);
    endfunction

    function automatic component_t make_component(input logic [31:0] x, input logic [31:0] v,
                                                  input logic [31:0] g,
                                                  input logic [DT_W-1:0] dt, input logic last);
        component_t c;
        c.position       = x;
        c.speed          = v;
        c.goal           = g;
        c.time_step      = dt;
        c.last_component = last;
        return c;
    endfunction

    function automatic logic [31:0] near_word(input int unsigned span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    function automatic logic [31:0] wild_word();
        case ($urandom_range(0, 8))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [DT_W-1:0] pick_time_step();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return DT_W'($urandom());
            4, 5:    return DT_W'($urandom_range(0, 65536));
            default: return DT_W'($urandom_range(1000, 1200));   // around one frame
        endcase
    endfunction

    // Send one component word, with an optional gap ahead of it
    task automatic send_component(input component_t c);
        int gap;
        gap = ($urandom_range(0, 99) < tx_gap_pct) ? idle_length() : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= S_TDATA_W'({c.time_step, c.goal, c.speed, c.position});
        s_tlast  <= c.last_component;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        record_component(c);
    endtask

    // Wait for all results, then for the block to go idle
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (pending_steps.size() != 0) @(posedge aclk);
        repeat (BLOCK_LATENCY + 8) @(posedge aclk);
    endtask

    // Write all four registers back to back; block must be idle
    task automatic load_registers(input logic [CFG_W-1:0] m, input logic [CFG_W-1:0] k,
                                  input logic [CFG_W-1:0] c, input logic [THR_W-1:0] thr);
        cfg_reg_t         order[4];
        logic [THR_W-1:0] value[4];
        order = '{REG_MASS, REG_STIFFNESS, REG_DAMPING, REG_THRESHOLD};
        value = '{{1'b0, m}, {1'b0, k}, {1'b0, c}, thr};
        for (int i = 0; i < 4; i++) begin
            cfg_index <= order[i];
            cfg_data  <= value[i];
            cfg_valid <= 1'b1;
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            apply_register(order[i], value[i]);
        end
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // One animated value: several components, the last one marked
    task automatic send_value(input motion_kind_t kind, input int parts);
        component_t  c;
        logic [31:0] g;
        for (int i = 0; i < parts; i++) begin
            case (kind)
                MOTION_REST: begin
                    g = near_word(100 << 16);
                    c = make_component(g + near_word(32), near_word(32), g,
                                       pick_time_step(), i == parts - 1);
                end
                MOTION_TYPICAL:
                    c = make_component(near_word(100 << 16), near_word(100 << 16),
                                       near_word(100 << 16), pick_time_step(), i == parts - 1);
                default:
                    c = make_component(wild_word(), wild_word(), wild_word(),
                                       pick_time_step(), i == parts - 1);
            endcase
            send_component(c);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_rest_and_extremes();
        settle_block();
        load_registers(MASS_RST, STIFFNESS_RST, DAMPING_RST, THRESHOLD_RST);
        send_component(make_component(32'h0, 32'h0, 32'h0, '0, 1'b1));
        // large speed over a long step pushes position past either rail
        send_component(make_component(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, 1'b0));
        send_component(make_component(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '1, 1'b1));
        // widest positive and negative displacement
        send_component(make_component(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, '0, 1'b0));
        send_component(make_component(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 20'd1, 1'b1));
        send_component(make_component(32'h0001_0000, 32'h0, 32'h0, 20'd1092, 1'b0));
        send_component(make_component(32'hFFFF_0000, 32'h0000_8000, 32'h0, 20'd1092, 1'b1));
    endtask

    task automatic test_speed_saturation();
        settle_block();
        // tiny mass, stiff spring: quotient overruns, energy sum clamps
        load_registers(31'd1, '1, '0, '1);
        send_component(make_component(32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 20'd1, 1'b0));
        send_component(make_component(32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 20'd1, 1'b1));
        send_component(make_component(32'h1234_5678, 32'h8000_0000, 32'h1234_5678, '0, 1'b1));
    endtask

    task automatic test_zero_mass();
        settle_block();
        // zero mass with no damping leaves a zero denominator
        load_registers('0, STIFFNESS_RST, '0, THRESHOLD_RST);
        send_component(make_component(32'h0001_0000, 32'h0003_0000, 32'h0, 20'd1, 1'b0));
        send_component(make_component(32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 20'd1, 1'b0));
        send_component(make_component(32'h0005_0000, 32'hFFF0_0000, 32'h0, '0, 1'b1));
    endtask

    task automatic test_finish_threshold();
        component_t       c;
        step_result_t     r;
        logic [SUM_W-1:0] e;
        logic [THR_W-1:0] edge_thr;
        settle_block();
        load_registers(MASS_RST, STIFFNESS_RST, DAMPING_RST, THRESHOLD_RST);
        c = make_component(32'h0001_8000, 32'h0000_4000, 32'h0001_0000, 20'd1092, 1'b1);
        integrate_component(c, r, e);
        edge_thr = (e > SUM_W'(32'hFFFF_FFFF)) ? '1 : THR_W'(e);

        // sum exactly at the threshold counts finished
        settle_block();
        load_registers(MASS_RST, STIFFNESS_RST, DAMPING_RST, edge_thr);
        send_component(c);
        // two components of one value add up past it; not-last keeps the sum
        c.last_component = 1'b0;
        send_component(c);
        c.last_component = 1'b1;
        send_component(c);

        // one LSB under
        settle_block();
        load_registers(MASS_RST, STIFFNESS_RST, DAMPING_RST, edge_thr - 1'b1);
        send_component(c);

        // zero threshold with a value at rest, then the widest threshold
        settle_block();
        load_registers(MASS_RST, STIFFNESS_RST, DAMPING_RST, '0);
        send_component(make_component(32'h0002_0000, 32'h0, 32'h0002_0000, 20'd1092, 1'b1));
        settle_block();
        load_registers(MASS_RST, STIFFNESS_RST, DAMPING_RST, '1);
        send_component(make_component(32'h0002_0100, 32'h0000_0100, 32'h0002_0000, 20'd1092,
                                      1'b1));
    endtask

    task automatic test_random_motion();
        int           sent;
        int           parts;
        int           pick;
        motion_kind_t kind;
        for (int phase = 0; phase < 6; phase++) begin
            settle_block();
            case (phase)
                0: begin
                    load_registers(MASS_RST, STIFFNESS_RST, DAMPING_RST, THRESHOLD_RST);
                    tx_gap_pct = 30; rx_stall_pct = 30;
                end
                1: begin
                    load_registers('1, '1, '1, '1);
                    tx_gap_pct = 0; rx_stall_pct = 0;
                end
                2: begin
                    load_registers(31'd1, '0, '0, '0);
                    tx_gap_pct = 60; rx_stall_pct = 10;
                end
                4: begin
                    load_registers(CFG_W'($urandom()) | 31'd1, CFG_W'($urandom()),
                                   CFG_W'($urandom()), $urandom());
                    tx_gap_pct = 40; rx_stall_pct = 40;
                end
                default: begin
                    load_registers(CFG_W'($urandom_range(6554, 10 << 16)),
                                   CFG_W'($urandom_range(0, 100 << 16)),
                                   CFG_W'($urandom_range(0, 20 << 16)),
                                   $urandom_range(0, 1 << 24));
                    tx_gap_pct   = (phase == 3) ? 20 : 10;
                    rx_stall_pct = (phase == 3) ? 50 : 10;
                end
            endcase
            sent = 0;
            while (sent < 62) begin
                parts = $urandom_range(1, 4);
                pick  = $urandom_range(0, 99);
                kind  = (pick < 40) ? MOTION_REST : (pick < 75) ? MOTION_TYPICAL : MOTION_WILD;
                send_value(kind, parts);
                sent += parts;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result sink with random stalls
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < rx_stall_pct) begin
            rx_hold = idle_length() - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        n_errors++;
        if (n_errors <= 30)
            $display("mismatch on result word %0d: %s got %08h expected %08h",
                     n_results, field, got, want);
    endtask

    // Compare each accepted result word with the oldest prediction
    always @(posedge aclk) begin
        step_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_steps.size() == 0) begin
                report_mismatch("unexpected word", m_tdata[31:0], '0);
            end else begin
                want = pending_steps.pop_front();
                if (m_tdata[31:0] !== want.new_position)
                    report_mismatch("new_position", m_tdata[31:0], want.new_position);
                if (m_tdata[63:32] !== want.new_speed)
                    report_mismatch("new_speed", m_tdata[63:32], want.new_speed);
                if (m_tlast !== want.is_last)
                    report_mismatch("is_last", 32'(m_tlast), 32'(want.is_last));
                if (m_tuser !== want.finished)
                    report_mismatch("finished", 32'(m_tuser), 32'(want.finished));
            end
            n_results++;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        spring_mass      = MASS_RST;
        spring_k         = STIFFNESS_RST;
        spring_c         = DAMPING_RST;
        finish_threshold = THRESHOLD_RST;
        energy_acc       = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        test_rest_and_extremes();
        test_speed_saturation();
        test_zero_mass();
        test_finish_threshold();
        test_random_motion();

        s_tvalid <= 1'b0;
        while (pending_steps.size() != 0) @(posedge aclk);
        repeat (2 * BLOCK_LATENCY) @(posedge aclk);

        $display("checked %0d components in %0d values under %0d register settings",
                 n_components, n_values, n_settings);
        $display("%0d values reported finished, %0d mismatches", n_finished, n_errors);
        if (n_errors == 0)
            $display("spring_damper_implicit_euler_step_test: clean");
        else
            $display("spring_damper_implicit_euler_step_test: errors");
        $finish;
    end

    // Hard stop if the handshakes hang
    initial begin
        #20_000_000;
        $display("timeout with %0d results still pending", pending_steps.size());
        $display("spring_damper_implicit_euler_step_test: errors");
        $finish;
    end

endmodule
